// ===== hw/rtl/pilot_tone_pll_nco_assert.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the pilot tone PLL oscillator
// Short forms of the concurrent assertions used in the RTL.
// ----------------------------------------------------------------------------
`ifndef PILOT_TONE_PLL_NCO_ASSERT_SVH
`define PILOT_TONE_PLL_NCO_ASSERT_SVH

// Implication checked on every clock edge outside reset.
`define PTP_ASSERT_IMPL(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication checked outside reset.
`define PTP_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hw/rtl/ptpll_pkg.sv =====
// ----------------------------------------------------------------------------
// ptpll_pkg
// Shared types, constants and the arctangent table of the pilot tone PLL.
// ----------------------------------------------------------------------------
package ptpll_pkg;

    localparam int SAMPLE_BITS_DEF    = 16;
    localparam int PHASE_BITS_DEF     = 32;
    localparam int CORDIC_STEPS_DEF   = 16;
    localparam int GAIN_FRAC_BITS_DEF = 24;

    localparam int STEP_W   = 31;
    localparam int GAIN_W   = 24;
    localparam int MULT_W   = 4;
    localparam int OFFSET_W = 32;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DATA_W = 32;

    localparam logic [CFG_IDX_W-1:0] REG_PHASE_STEP  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_PROP_GAIN   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_INTEG_GAIN  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_NCO_MULT    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_OUT_OFFSET  = 3'd4;

    localparam logic [STEP_W-1:0] PHASE_STEP_RST = 31'd340018245;
    localparam logic [GAIN_W-1:0] PROP_GAIN_RST  = 24'd447281;
    localparam logic [GAIN_W-1:0] INTEG_GAIN_RST = 24'd5964;
    localparam logic [MULT_W-1:0] NCO_MULT_RST   = 4'd2;

    localparam logic [31:0] GAIN_KQ32 = 32'd2608131496;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_MIX,
        ST_VEC_INIT,
        ST_VEC_RUN,
        ST_FILT_MUL,
        ST_FILT_ADD,
        ST_ROT1_INIT,
        ST_ROT1_RUN,
        ST_ROT2_INIT,
        ST_ROT2_RUN,
        ST_OUT
    } ptpll_state_t;

    typedef struct packed {
        logic load;
        logic mix;
        logic vec_init;
        logic rot_init_fb;
        logic rot_init_out;
        logic step;
        logic filt_mul;
        logic filt_add;
        logic store_fb;
        logic emit;
    } ptpll_cmd_t;

    typedef struct packed {
        logic last_step;
    } ptpll_status_t;

    function automatic logic [31:0] atan_turns32(input logic [4:0] i);
        logic [31:0] v;
        begin
            unique case (i)
                5'd0:  v = 32'h20000000;
                5'd1:  v = 32'h12E4051E;
                5'd2:  v = 32'h09FB385B;
                5'd3:  v = 32'h051111D4;
                5'd4:  v = 32'h028B0D43;
                5'd5:  v = 32'h0145D7E1;
                5'd6:  v = 32'h00A2F61E;
                5'd7:  v = 32'h00517C55;
                5'd8:  v = 32'h0028BE53;
                5'd9:  v = 32'h00145F2F;
                5'd10: v = 32'h000A2F98;
                5'd11: v = 32'h000517CC;
                5'd12: v = 32'h00028BE6;
                5'd13: v = 32'h000145F3;
                5'd14: v = 32'h0000A2FA;
                5'd15: v = 32'h0000517D;
                5'd16: v = 32'h000028BE;
                5'd17: v = 32'h0000145F;
                5'd18: v = 32'h00000A30;
                5'd19: v = 32'h00000518;
                5'd20: v = 32'h0000028C;
                5'd21: v = 32'h00000146;
                5'd22: v = 32'h000000A3;
                5'd23: v = 32'h00000051;
                5'd24: v = 32'h00000029;
                5'd25: v = 32'h00000014;
                5'd26: v = 32'h0000000A;
                5'd27: v = 32'h00000005;
                5'd28: v = 32'h00000003;
                5'd29: v = 32'h00000001;
                5'd30: v = 32'h00000001;
                default: v = 32'h00000000;
            endcase
            return v;
        end
    endfunction

endpackage

// ===== hw/rtl/pilot_tone_pll_nco.sv =====
// ----------------------------------------------------------------------------
// pilot_tone_pll_nco
// Second-order PLL locked to a real pilot tone, with an oscillator output.
// ----------------------------------------------------------------------------
// Each request takes one sample and gives one cosine value. A single shared
// CORDIC runs one vectoring pass and two rotations in turn for each request;
// a new sample is taken only once the previous result has been handed over
// to the output register.
module pilot_tone_pll_nco
    import ptpll_pkg::*;
#(
    parameter int SAMPLE_BITS    = SAMPLE_BITS_DEF,
    parameter int PHASE_BITS     = PHASE_BITS_DEF,
    parameter int CORDIC_STEPS   = CORDIC_STEPS_DEF,
    parameter int GAIN_FRAC_BITS = GAIN_FRAC_BITS_DEF
)(
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [CFG_IDX_W-1:0]          cfg_index,
    input  logic [CFG_DATA_W-1:0]         cfg_data,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic signed [SAMPLE_BITS-1:0] s_sample,
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic signed [SAMPLE_BITS-1:0] m_nco_value
);

    logic [STEP_W-1:0]   phase_step_reg;
    logic [GAIN_W-1:0]   prop_gain_reg, integ_gain_reg;
    logic [MULT_W-1:0]   nco_mult_reg;
    logic [OFFSET_W-1:0] out_offset_reg;
    ptpll_cmd_t          cmd;
    ptpll_status_t       status;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_step_reg <= PHASE_STEP_RST;
            prop_gain_reg  <= PROP_GAIN_RST;
            integ_gain_reg <= INTEG_GAIN_RST;
            nco_mult_reg   <= NCO_MULT_RST;
            out_offset_reg <= '0;
        end else if (cfg_valid) begin
            unique case (cfg_index)
                REG_PHASE_STEP: phase_step_reg <= cfg_data[STEP_W-1:0];
                REG_PROP_GAIN:  prop_gain_reg  <= cfg_data[GAIN_W-1:0];
                REG_INTEG_GAIN: integ_gain_reg <= cfg_data[GAIN_W-1:0];
                REG_NCO_MULT:   nco_mult_reg   <= cfg_data[MULT_W-1:0];
                REG_OUT_OFFSET: out_offset_reg <= cfg_data[OFFSET_W-1:0];
                default: ;
            endcase
        end
    end

    ptpll_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .status  (status),
        .cmd     (cmd)
    );

    ptpll_datapath #(
        .SAMPLE_BITS    (SAMPLE_BITS),
        .PHASE_BITS     (PHASE_BITS),
        .CORDIC_STEPS   (CORDIC_STEPS),
        .GAIN_FRAC_BITS (GAIN_FRAC_BITS)
    ) u_dp (
        .aclk                (aclk),
        .aresetn             (aresetn),
        .cmd                 (cmd),
        .status              (status),
        .s_sample            (s_sample),
        .phase_step          (phase_step_reg),
        .proportional_gain   (prop_gain_reg),
        .integral_gain       (integ_gain_reg),
        .nco_multiplier      (nco_mult_reg),
        .output_phase_offset (out_offset_reg),
        .m_nco_value         (m_nco_value)
    );

endmodule

// ===== hw/rtl/ptpll_ctrl.sv =====
// ----------------------------------------------------------------------------
// ptpll_ctrl
// Sequencer of the pilot tone PLL: steps the shared CORDIC through vectoring,
// the loop filter and two rotations for every request.
// ----------------------------------------------------------------------------
module ptpll_ctrl
    import ptpll_pkg::*;
(
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          s_valid,
    output logic          s_ready,
    output logic          m_valid,
    input  logic          m_ready,
    input  ptpll_status_t status,
    output ptpll_cmd_t    cmd
);

    ptpll_state_t state_reg, state_next;
    logic         out_valid_reg, out_valid_next;

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:      if (s_valid) state_next = ST_MIX;
            ST_MIX:       state_next = ST_VEC_INIT;
            ST_VEC_INIT:  state_next = ST_VEC_RUN;
            ST_VEC_RUN:   if (status.last_step) state_next = ST_FILT_MUL;
            ST_FILT_MUL:  state_next = ST_FILT_ADD;
            ST_FILT_ADD:  state_next = ST_ROT1_INIT;
            ST_ROT1_INIT: state_next = ST_ROT1_RUN;
            ST_ROT1_RUN:  if (status.last_step) state_next = ST_ROT2_INIT;
            ST_ROT2_INIT: state_next = ST_ROT2_RUN;
            ST_ROT2_RUN:  if (status.last_step) state_next = ST_OUT;
            ST_OUT:       if (!out_valid_reg || m_ready) state_next = ST_IDLE;
            default:      state_next = ST_IDLE;
        endcase
    end

    always_comb begin
        cmd = '0;
        s_ready = (state_reg == ST_IDLE);
        unique case (state_reg)
            ST_IDLE:      cmd.load = s_valid;
            ST_MIX:       cmd.mix = 1'b1;
            ST_VEC_INIT:  cmd.vec_init = 1'b1;
            ST_VEC_RUN:   cmd.step = 1'b1;
            ST_FILT_MUL:  cmd.filt_mul = 1'b1;
            ST_FILT_ADD:  cmd.filt_add = 1'b1;
            ST_ROT1_INIT: cmd.rot_init_fb = 1'b1;
            ST_ROT1_RUN:  cmd.step = 1'b1;
            ST_ROT2_INIT: begin
                cmd.store_fb = 1'b1;
                cmd.rot_init_out = 1'b1;
            end
            ST_ROT2_RUN:  cmd.step = 1'b1;
            ST_OUT:       cmd.emit = !out_valid_reg || m_ready;
            default:      cmd = '0;
        endcase
    end

    always_comb begin
        out_valid_next = out_valid_reg;
        if (m_ready) out_valid_next = 1'b0;
        if (cmd.emit) out_valid_next = 1'b1;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign m_valid = out_valid_reg;

`include "pilot_tone_pll_nco_assert.svh"
    `PTP_ASSERT_IMPL(a_accept_idle, aclk, aresetn, s_valid && s_ready, state_reg == ST_IDLE, "request accepted outside idle")
    `PTP_ASSERT_NEXT(a_emit_valid, aclk, aresetn, cmd.emit, m_valid, "emitted result not shown")
    `PTP_ASSERT_NEXT(a_hold_out, aclk, aresetn, m_valid && !m_ready && state_reg != ST_OUT, m_valid, "result dropped")

endmodule

// ===== hw/rtl/ptpll_datapath.sv =====
// ----------------------------------------------------------------------------
// ptpll_datapath
// Mixer, shared CORDIC, loop filter and phase registers of the pilot tone PLL.
// ----------------------------------------------------------------------------
module ptpll_datapath
    import ptpll_pkg::*;
#(
    parameter int SAMPLE_BITS    = SAMPLE_BITS_DEF,
    parameter int PHASE_BITS     = PHASE_BITS_DEF,
    parameter int CORDIC_STEPS   = CORDIC_STEPS_DEF,
    parameter int GAIN_FRAC_BITS = GAIN_FRAC_BITS_DEF
)(
    input  logic                          aclk,
    input  logic                          aresetn,
    input  ptpll_cmd_t                    cmd,
    output ptpll_status_t                 status,
    input  logic signed [SAMPLE_BITS-1:0] s_sample,
    input  logic [STEP_W-1:0]             phase_step,
    input  logic [GAIN_W-1:0]             proportional_gain,
    input  logic [GAIN_W-1:0]             integral_gain,
    input  logic [MULT_W-1:0]             nco_multiplier,
    input  logic [OFFSET_W-1:0]           output_phase_offset,
    output logic signed [SAMPLE_BITS-1:0] m_nco_value
);

    localparam int PW   = PHASE_BITS;
    localparam int IW   = PHASE_BITS + 8;
    localparam int MW   = 2 * SAMPLE_BITS + 1;
    localparam int CW   = (MW > SAMPLE_BITS + 18 ? MW : SAMPLE_BITS + 18) + 2;
    localparam int STEPS = (CORDIC_STEPS < 32) ? CORDIC_STEPS : 32;
    localparam int CNT_W = $clog2(STEPS + 1);
    localparam int PRW  = PW + GAIN_W + 1;
    localparam logic signed [CW-1:0] AMP = CW'((64'sd1 <<< (SAMPLE_BITS - 1)) - 1);
    localparam logic [PW-1:0] HALF = PW'(1) << (PW - 1);
    localparam logic [PW-1:0] QUARTER = PW'(1) << (PW - 2);
    localparam logic signed [IW-1:0] ILIM = {1'b0, {(IW-1){1'b1}}};
    localparam logic signed [IW-1:0] IMIN = {1'b1, {(IW-1){1'b0}}};
    localparam logic [63:0] X0_FULL = 64'(AMP) * 64'(GAIN_KQ32);
    localparam logic signed [CW-1:0] ROT_X0 = CW'(X0_FULL >> 16);

    logic signed [CW-1:0]          x_reg, y_reg;
    logic [PW-1:0]                 z_reg;
    logic                          vec_mode_reg, neg_reg, zero_vec_reg;
    logic [CNT_W-1:0]              cnt_reg;
    logic signed [SAMPLE_BITS-1:0] samp_reg;
    logic signed [SAMPLE_BITS-1:0] fb_cos_reg, fb_sin_reg;
    logic signed [MW-1:0]          mi_reg, mq_reg;
    logic signed [PRW-1:0]         pprod_reg, iprod_reg;
    logic signed [IW-1:0]          integ_reg;
    logic [PW-1:0]                 est_reg, carrier_reg, theta_reg;
    logic signed [SAMPLE_BITS-1:0] out_reg;

    logic [31:0]          atan32;
    logic [PW-1:0]        atan_a;
    logic [4:0]           step_idx;
    logic signed [CW-1:0] dx, dy;
    logic                 dir_up;
    logic signed [PW-1:0] err;
    logic signed [PRW-1:0] pterm, iterm;
    logic signed [IW+1:0] isum;
    logic signed [IW-1:0] integ_next;
    logic [PW-1:0]        theta_next, ot;
    logic signed [CW-1:0] cr_raw, sr_raw, cr, sr;
    logic signed [SAMPLE_BITS-1:0] c_sat, s_sat;

    function automatic logic [PW-1:0] rot_start_z(input logic [PW-1:0] th);
        logic signed [PW-1:0] zs;
        begin
            zs = $signed(th);
            if (zs > $signed(QUARTER) || zs < -$signed(QUARTER)) return th + HALF;
            return th;
        end
    endfunction

    function automatic logic signed [SAMPLE_BITS-1:0] clampv(input logic signed [CW-1:0] v);
        begin
            if (v > AMP) return SAMPLE_BITS'(AMP);
            if (v < -AMP) return SAMPLE_BITS'(-AMP);
            return v[SAMPLE_BITS-1:0];
        end
    endfunction

    assign step_idx = 5'(cnt_reg);
    assign atan32 = atan_turns32(step_idx);
    generate
        if (PW >= 32) begin : g_wide
            assign atan_a = PW'(atan32) << (PW - 32);
        end else begin : g_narrow
            assign atan_a = PW'(atan32 >> (32 - PW));
        end
    endgenerate

    assign dx = y_reg >>> cnt_reg;
    assign dy = x_reg >>> cnt_reg;
    assign dir_up = vec_mode_reg ? (y_reg > 0) : !z_reg[PW-1];
    assign status.last_step = (cnt_reg == CNT_W'(STEPS - 1)) || (STEPS == 0);

    assign err   = zero_vec_reg ? '0 : $signed(z_reg);
    assign pterm = pprod_reg >>> GAIN_FRAC_BITS;
    assign iterm = iprod_reg >>> GAIN_FRAC_BITS;
    assign isum  = (IW+2)'(integ_reg) + (IW+2)'(iterm);
    always_comb begin
        if (isum > (IW+2)'(ILIM)) integ_next = ILIM;
        else if (isum < (IW+2)'(IMIN)) integ_next = IMIN;
        else integ_next = isum[IW-1:0];
    end
    assign theta_next = carrier_reg + PW'(phase_step) + est_reg + PW'(pterm) + PW'(integ_next);
    assign ot = PW'(theta_reg * nco_multiplier) + PW'(output_phase_offset);

    assign cr_raw = (x_reg + CW'(32768)) >>> 16;
    assign sr_raw = (y_reg + CW'(32768)) >>> 16;
    assign cr = neg_reg ? -cr_raw : cr_raw;
    assign sr = neg_reg ? -sr_raw : sr_raw;
    assign c_sat = clampv(cr);
    assign s_sat = clampv(sr);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            integ_reg   <= '0;
            est_reg     <= '0;
            carrier_reg <= '0;
            fb_cos_reg  <= SAMPLE_BITS'(AMP);
            fb_sin_reg  <= '0;
            cnt_reg     <= '0;
        end else begin
            if (cmd.load) samp_reg <= s_sample;
            if (cmd.mix) begin
                mi_reg <= MW'(samp_reg) * MW'(fb_cos_reg);
                mq_reg <= -(MW'(samp_reg) * MW'(fb_sin_reg));
            end
            if (cmd.vec_init) begin
                vec_mode_reg <= 1'b1;
                cnt_reg      <= '0;
                zero_vec_reg <= (mi_reg == 0) && (mq_reg == 0);
                if (mi_reg < 0) begin
                    x_reg <= -CW'(mi_reg);
                    y_reg <= -CW'(mq_reg);
                    z_reg <= HALF;
                end else begin
                    x_reg <= CW'(mi_reg);
                    y_reg <= CW'(mq_reg);
                    z_reg <= '0;
                end
            end
            if (cmd.step) begin
                cnt_reg <= cnt_reg + 1'b1;
                if (dir_up == vec_mode_reg) begin
                    x_reg <= x_reg + dx;
                    y_reg <= y_reg - dy;
                end else begin
                    x_reg <= x_reg - dx;
                    y_reg <= y_reg + dy;
                end
                if (dir_up) z_reg <= vec_mode_reg ? z_reg + atan_a : z_reg - atan_a;
                else z_reg <= vec_mode_reg ? z_reg - atan_a : z_reg + atan_a;
            end
            if (cmd.filt_mul) begin
                pprod_reg <= $signed({1'b0, proportional_gain}) * err;
                iprod_reg <= $signed({1'b0, integral_gain}) * err;
            end
            if (cmd.filt_add) begin
                integ_reg   <= integ_next;
                est_reg     <= est_reg + PW'(pterm) + PW'(integ_next);
                carrier_reg <= carrier_reg + PW'(phase_step);
                theta_reg   <= theta_next;
            end
            if (cmd.rot_init_fb || cmd.rot_init_out) begin
                vec_mode_reg <= 1'b0;
                cnt_reg      <= '0;
                x_reg        <= ROT_X0;
                y_reg        <= '0;
                z_reg        <= rot_start_z(cmd.rot_init_fb ? theta_reg : ot);
                neg_reg      <= rot_start_z(cmd.rot_init_fb ? theta_reg : ot)
                                != (cmd.rot_init_fb ? theta_reg : ot);
            end
            if (cmd.store_fb) begin
                fb_cos_reg <= c_sat;
                fb_sin_reg <= s_sat;
            end
            if (cmd.emit) out_reg <= c_sat;
        end
    end

    assign m_nco_value = out_reg;

`include "pilot_tone_pll_nco_assert.svh"
    `PTP_ASSERT_IMPL(a_fb_range, aclk, aresetn, 1'b1, fb_cos_reg != -(SAMPLE_BITS'(AMP)) - 1'b1, "feedback out of range")
    `PTP_ASSERT_IMPL(a_cnt_range, aclk, aresetn, cmd.step, cnt_reg < CNT_W'(STEPS), "CORDIC step count overrun")
    `PTP_ASSERT_NEXT(a_integ_hold, aclk, aresetn, !cmd.filt_add, $stable(integ_reg), "integrator moved outside update")

endmodule

// ===== verif/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the pilot tone PLL oscillator. Samples are driven
// through the request channel with random gaps, the loop is modelled in
// fixed point alongside the block, and every output cosine is compared with
// the modelled value. Registers are rewritten between phases while idle.
// ----------------------------------------------------------------------------
module tb_top;
    import ptpll_pkg::*;

    localparam int LIMIT = 20000;
    localparam int HOLD_LEN = 600;

    logic                   aclk = 1'b0;
    logic                   aresetn = 1'b0;
    logic                   cfg_valid = 1'b0;
    logic                   cfg_ready;
    logic [CFG_IDX_W-1:0]   cfg_index = '0;
    logic [CFG_DATA_W-1:0]  cfg_data = '0;
    logic                   s_valid = 1'b0;
    logic                   s_ready;
    logic signed [15:0]     s_sample = '0;
    logic                   m_valid;
    logic                   m_ready = 1'b0;
    logic signed [15:0]     m_nco_value;

    pilot_tone_pll_nco u_dut (
        .aclk(aclk), .aresetn(aresetn),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_index(cfg_index), .cfg_data(cfg_data),
        .s_valid(s_valid), .s_ready(s_ready), .s_sample(s_sample),
        .m_valid(m_valid), .m_ready(m_ready), .m_nco_value(m_nco_value)
    );

    always #5 aclk = ~aclk;

    // Loop model state and registers.
    logic [30:0]        step_r;
    logic [23:0]        kp_r, ki_r;
    logic [3:0]         mult_r;
    logic [31:0]        offs_r;
    longint             integ_acc;
    logic [31:0]        est_ph, carr_ph;
    longint             fb_cos, fb_sin;

    logic signed [15:0] sample_q[$];
    logic signed [15:0] cosine_q[$];
    int                 errors = 0;
    int                 idle_cycles = 0;
    int                 hold_cnt = 0;
    bit                 rx_hold = 1'b0;
    bit                 tx_pause = 1'b0;
    bit                 s_taken = 1'b0;

    function automatic longint sra(longint v, int s);
        return v >>> s;
    endfunction

    function automatic longint as_signed32(logic [31:0] u);
        return longint'($signed(u));
    endfunction

    function automatic logic [31:0] vec_angle(longint x, longint y);
        logic [31:0] z;
        longint dx, dy;
        z = '0;
        if (x == 0 && y == 0)
            return '0;
        if (x < 0) begin
            x = -x;
            y = -y;
            z = 32'h8000_0000;
        end
        for (int i = 0; i < 16; i++) begin
            dx = sra(y, i);
            dy = sra(x, i);
            if (y > 0) begin
                x += dx; y -= dy; z += atan_turns32(i[4:0]);
            end else begin
                x -= dx; y += dy; z -= atan_turns32(i[4:0]);
            end
        end
        return z;
    endfunction

    function automatic longint clamp_amp(longint v);
        if (v > 32767) return 32767;
        if (v < -32767) return -32767;
        return v;
    endfunction

    task automatic rotate_phase(input logic [31:0] th, output longint c, output longint s);
        longint z, x, y, dx, dy, cr, sr;
        bit     neg;
        z = as_signed32(th);
        neg = 1'b0;
        y = 0;
        if (z > 64'sh4000_0000 || z < -64'sh4000_0000) begin
            z = as_signed32(th + 32'h8000_0000);
            neg = 1'b1;
        end
        x = sra(32767 * longint'(GAIN_KQ32), 16);
        for (int i = 0; i < 16; i++) begin
            dx = sra(y, i);
            dy = sra(x, i);
            if (z >= 0) begin
                x -= dx; y += dy; z -= longint'(atan_turns32(i[4:0]));
            end else begin
                x += dx; y -= dy; z += longint'(atan_turns32(i[4:0]));
            end
        end
        cr = sra(x + 32768, 16);
        sr = sra(y + 32768, 16);
        if (neg) begin
            cr = -cr;
            sr = -sr;
        end
        c = clamp_amp(cr);
        s = clamp_amp(sr);
    endtask

    task automatic predict_cosine(input logic signed [15:0] smp);
        longint      x, err, pterm, ilim, c, s;
        logic [31:0] theta, ot;
        x = longint'(smp);
        ilim = (longint'(1) <<< 39) - 1;
        err = as_signed32(vec_angle(x * fb_cos, -(x * fb_sin)));
        integ_acc = integ_acc + sra(longint'(ki_r) * err, 24);
        if (integ_acc > ilim) integ_acc = ilim;
        if (integ_acc < -ilim - 1) integ_acc = -ilim - 1;
        pterm = sra(longint'(kp_r) * err, 24);
        est_ph = est_ph + pterm[31:0] + integ_acc[31:0];
        carr_ph = carr_ph + {1'b0, step_r};
        theta = carr_ph + est_ph;
        rotate_phase(theta, fb_cos, fb_sin);
        ot = theta * {28'd0, mult_r} + offs_r;
        rotate_phase(ot, c, s);
        cosine_q.push_back(c[15:0]);
    endtask

    task automatic report(input string what, input logic signed [15:0] got,
                          input logic signed [15:0] want);
        $display("mismatch %s: got %0d expected %0d", what, got, want);
        errors++;
    endtask

    // Acceptance of the request on offer at the last rising edge.
    always @(posedge aclk) begin
        s_taken <= s_valid && s_ready;
    end

    // Sender.
    always @(negedge aclk) begin
        if (s_valid && !s_taken) begin
        end else if (sample_q.size() > 0 && !tx_pause && $urandom_range(0, 3) != 0) begin
            s_valid <= 1'b1;
            s_sample <= sample_q.pop_front();
        end else begin
            s_valid <= 1'b0;
        end
    end

    // Receiver.
    always @(negedge aclk) begin
        if (rx_hold && hold_cnt < HOLD_LEN) begin
            m_ready <= 1'b0;
            hold_cnt <= hold_cnt + 1;
        end else if ($urandom_range(0, 19) == 0)
            m_ready <= 1'b0;
        else
            m_ready <= ($urandom_range(0, 3) != 0);
    end

    // Monitor: prediction at sample acceptance, comparison at result.
    always @(posedge aclk) begin
        if (aresetn) begin
            if (s_valid && s_ready)
                predict_cosine(s_sample);
            if (m_valid && m_ready) begin
                if (cosine_q.size() == 0)
                    report("unexpected", m_nco_value, 16'sd0);
                else if (m_nco_value !== cosine_q[0])
                    report("nco_value", m_nco_value, cosine_q.pop_front());
                else
                    void'(cosine_q.pop_front());
            end
            if ((s_valid && s_ready) || (m_valid && m_ready) || (cfg_valid && cfg_ready))
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
            if (idle_cycles > LIMIT) begin
                $display("tb_top NOT OK");
                $finish;
            end
        end
    end

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] val);
        @(negedge aclk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        case (idx)
            REG_PHASE_STEP: step_r = val[30:0];
            REG_PROP_GAIN:  kp_r = val[23:0];
            REG_INTEG_GAIN: ki_r = val[23:0];
            REG_NCO_MULT:   mult_r = val[3:0];
            REG_OUT_OFFSET: offs_r = val;
            default: ;
        endcase
        @(negedge aclk);
        cfg_valid <= 1'b0;
    endtask

    task automatic drain();
        while (sample_q.size() > 0 || s_valid || cosine_q.size() > 0) @(posedge aclk);
        repeat (80) @(posedge aclk);
    endtask

    task automatic queue_random(input int n);
        int k;
        for (int i = 0; i < n; i++) begin
            k = $urandom_range(0, 9);
            if (k < 6)
                sample_q.push_back(16'(int'(20000.0 * $cos(6.2831853 * i * 0.08))
                                   + $signed(16'($urandom_range(0, 2000))) - 1000));
            else if (k < 8)
                sample_q.push_back(16'($urandom));
            else if (k == 8)
                sample_q.push_back($urandom_range(0, 1) ? 16'sh8000 : 16'sh7fff);
            else
                sample_q.push_back(16'sd0);
        end
    endtask

    initial begin
        step_r = PHASE_STEP_RST;
        kp_r = PROP_GAIN_RST;
        ki_r = INTEG_GAIN_RST;
        mult_r = NCO_MULT_RST;
        offs_r = '0;
        integ_acc = 0;
        est_ph = '0;
        carr_ph = '0;
        fb_cos = 32767;
        fb_sin = 0;
        repeat (8) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // Directed samples at reset settings.
        sample_q.push_back(16'sh7fff);
        sample_q.push_back(16'sh8000);
        sample_q.push_back(16'sd0);
        sample_q.push_back(16'sd0);
        sample_q.push_back(-16'sd1);
        sample_q.push_back(16'sd1);
        sample_q.push_back(16'sh5555);
        sample_q.push_back(16'shaaaa);
        drain();

        // Extremes of every register.
        write_reg(REG_PHASE_STEP, 32'h7fff_ffff);
        write_reg(REG_PROP_GAIN, 32'h00ff_ffff);
        write_reg(REG_INTEG_GAIN, 32'h00ff_ffff);
        write_reg(REG_NCO_MULT, 32'd0);
        write_reg(REG_OUT_OFFSET, 32'hffff_ffff);
        for (int i = 0; i < 8; i++) sample_q.push_back(i[0] ? 16'sh7fff : 16'sh8000);
        drain();
        write_reg(REG_NCO_MULT, 32'd15);
        write_reg(REG_PHASE_STEP, 32'd0);
        write_reg(REG_PROP_GAIN, 32'd0);
        write_reg(REG_INTEG_GAIN, 32'd0);
        write_reg(REG_OUT_OFFSET, 32'h8000_0000);
        for (int i = 0; i < 6; i++) sample_q.push_back(16'($urandom));
        drain();

        // Random phases, with one long receiver hold-off and one sender pause.
        for (int ph = 0; ph < 6; ph++) begin
            write_reg(REG_PHASE_STEP, $urandom_range(0, 32'h7fff_ffff));
            write_reg(REG_PROP_GAIN, (ph == 5) ? 32'd447281 : $urandom_range(0, 24'hffffff));
            write_reg(REG_INTEG_GAIN, (ph == 5) ? 32'd5964 : $urandom_range(0, 24'hffffff));
            write_reg(REG_NCO_MULT, $urandom_range(1, 8));
            write_reg(REG_OUT_OFFSET, $urandom);
            queue_random(150);
            if (ph == 1) begin
                rx_hold = 1'b1;
                while (hold_cnt < HOLD_LEN) @(posedge aclk);
                rx_hold = 1'b0;
            end
            if (ph == 2) begin
                while (sample_q.size() > 75) @(posedge aclk);
                tx_pause = 1'b1;
                while (s_valid || cosine_q.size() > 0) @(posedge aclk);
                tx_pause = 1'b0;
            end
            drain();
        end

        if (errors == 0)
            $display("tb_top OK");
        else
            $display("tb_top NOT OK");
        $finish;
    end

endmodule

// ===== filelist.f =====
+incdir+hw/rtl
hw/rtl/ptpll_pkg.sv
hw/rtl/ptpll_ctrl.sv
hw/rtl/ptpll_datapath.sv
hw/rtl/pilot_tone_pll_nco.sv
verif/tb_top.sv
